@@ design/bsa_pkg.sv @@
// Shared types, constants and codes for the bitmap slot allocator.
// No dependencies.
package bsa_pkg;

    localparam int CAPACITY   = 256;
    localparam int WORD_WIDTH = 32;
    localparam int NUM_WORDS  = CAPACITY / WORD_WIDTH;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int WORD_IDX_W = $clog2(NUM_WORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_WIDTH);
    localparam int SIZE_W     = SLOT_W + 1;
    localparam int ACT_W      = 2;
    localparam int STS_W      = 2;
    localparam int IN_DATA_W  = ((SLOT_W + 7) / 8) * 8;
    localparam int OUT_BITS   = SLOT_W + 1 + 2 * SIZE_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_RELEASE = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_QUERY   = ACT_W'(2);

    localparam logic [STS_W-1:0] STS_OK    = STS_W'(0);
    localparam logic [STS_W-1:0] STS_FULL  = STS_W'(1);
    localparam logic [STS_W-1:0] STS_RANGE = STS_W'(2);

    typedef logic [WORD_WIDTH-1:0] t_word;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic alloc_req;
        logic found;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ design/bsa_ctrl.sv @@
// Sequencing state machine for the allocator: request load, word scan, result.
// Depends on bsa_pkg.
module bsa_ctrl import bsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.alloc_req ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found || i_sts.last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/bsa_datapath.sv @@
// Occupancy bitmap, counters, word scanner and result register.
// Depends on bsa_pkg; driven by bsa_ctrl commands.
module bsa_datapath import bsa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [SIZE_W-1:0]      i_cfg_wr_data,
    input  logic [ACT_W-1:0]       i_action,
    input  logic [SLOT_W-1:0]      i_slot_index,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [STS_W-1:0]       o_status,
    output logic [SLOT_W-1:0]      o_granted_slot,
    output logic                   o_slot_bit,
    output logic [SIZE_W-1:0]      o_free_count,
    output logic [SIZE_W-1:0]      o_peak_used
);

    t_word                 r_words [NUM_WORDS];
    logic [SIZE_W-1:0]     r_size;
    logic [SIZE_W-1:0]     r_free;
    logic [SIZE_W-1:0]     r_peak;
    logic [ACT_W-1:0]      r_act;
    logic [SLOT_W-1:0]     r_idx;
    logic [WORD_IDX_W-1:0] r_wptr;
    logic                  r_found;
    logic [BIT_IDX_W-1:0]  r_hit_bit;
    logic                  r_out_valid;
    logic [STS_W-1:0]      r_status;
    logic [SLOT_W-1:0]     r_granted;
    logic                  r_sbit;
    logic [SIZE_W-1:0]     r_free_out;
    logic [SIZE_W-1:0]     r_peak_out;

    t_word                 rd_word;
    t_word                 free_mask;
    logic                  scan_found;
    logic [BIT_IDX_W-1:0]  scan_bit;
    logic [SIZE_W-1:0]     next_base;
    logic                  scan_last;
    logic [SIZE_W-1:0]     cfg_size;

    logic [BIT_IDX_W-1:0]  tgt_bit;
    logic                  cur_bit;
    logic                  idx_in_range;
    logic [STS_W-1:0]      n_status;
    logic [SLOT_W-1:0]     n_granted;
    logic                  n_sbit;
    logic [SIZE_W-1:0]     n_free;
    logic [SIZE_W-1:0]     n_peak;
    logic [SIZE_W-1:0]     used;
    t_word                 n_word;
    logic                  n_wr;

    assign rd_word  = r_words[r_wptr];
    assign cfg_size = (i_cfg_wr_data > SIZE_W'(CAPACITY)) ? SIZE_W'(CAPACITY) : i_cfg_wr_data;

    // free and managed bits of the current word, lowest one wins
    always_comb begin
        free_mask  = '0;
        scan_bit   = '0;
        scan_found = 1'b0;
        for (int b = 0; b < WORD_WIDTH; b++) begin
            free_mask[b] = !rd_word[b] &&
                           (SIZE_W'({r_wptr, BIT_IDX_W'(b)}) < r_size);
        end
        for (int b = WORD_WIDTH - 1; b >= 0; b--) begin
            if (free_mask[b]) begin
                scan_bit   = BIT_IDX_W'(b);
                scan_found = 1'b1;
            end
        end
    end

    assign next_base = SIZE_W'({r_wptr, {BIT_IDX_W{1'b0}}}) + SIZE_W'(WORD_WIDTH);
    assign scan_last = (r_wptr == WORD_IDX_W'(NUM_WORDS - 1)) || (next_base >= r_size);

    assign tgt_bit      = (r_act == ACT_ALLOC) ? r_hit_bit : r_idx[BIT_IDX_W-1:0];
    assign cur_bit      = rd_word[tgt_bit];
    assign idx_in_range = SIZE_W'(r_idx) < r_size;

    always_comb begin
        n_status  = STS_OK;
        n_granted = '0;
        n_sbit    = 1'b0;
        n_free    = r_free;
        n_peak    = r_peak;
        n_word    = rd_word;
        n_wr      = 1'b0;
        used      = '0;
        unique case (r_act)
            ACT_ALLOC: begin
                if (r_found) begin
                    n_word[tgt_bit] = 1'b1;
                    n_wr            = 1'b1;
                    n_granted       = {r_wptr, r_hit_bit};
                    if (r_free != '0) begin
                        n_free = r_free - SIZE_W'(1);
                    end
                    used = r_size - n_free;
                    if (used > r_peak) begin
                        n_peak = used;
                    end
                end else begin
                    n_status = STS_FULL;
                end
            end
            ACT_RELEASE: begin
                if (!idx_in_range) begin
                    n_status = STS_RANGE;
                end else if (cur_bit) begin
                    n_word[tgt_bit] = 1'b0;
                    n_wr            = 1'b1;
                    if (r_free < r_size) begin
                        n_free = r_free + SIZE_W'(1);
                    end
                end
            end
            ACT_QUERY: begin
                if (!idx_in_range) begin
                    n_status = STS_RANGE;
                end else begin
                    n_sbit = cur_bit;
                end
            end
            default: begin
                n_status = STS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_words[w] <= '0;
            end
            r_size      <= SIZE_W'(CAPACITY);
            r_free      <= SIZE_W'(CAPACITY);
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                for (int w = 0; w < NUM_WORDS; w++) begin
                    r_words[w] <= '0;
                end
                r_size <= cfg_size;
                r_free <= cfg_size;
                r_peak <= '0;
            end else if (i_cmd.commit) begin
                if (n_wr) begin
                    r_words[r_wptr] <= n_word;
                end
                r_free <= n_free;
                r_peak <= n_peak;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_idx   <= i_slot_index;
            r_wptr  <= (i_action == ACT_ALLOC) ? '0 : i_slot_index[SLOT_W-1 -: WORD_IDX_W];
            r_found <= 1'b0;
        end else if (i_cmd.scan) begin
            r_found   <= scan_found;
            r_hit_bit <= scan_bit;
            if (!scan_found && !scan_last) begin
                r_wptr <= r_wptr + WORD_IDX_W'(1);
            end
        end
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_granted  <= n_granted;
            r_sbit     <= n_sbit;
            r_free_out <= n_free;
            r_peak_out <= n_peak;
        end
    end

    assign o_sts.alloc_req = (i_action == ACT_ALLOC);
    assign o_sts.found     = scan_found;
    assign o_sts.last      = scan_last;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_granted_slot = r_granted;
    assign o_slot_bit     = r_sbit;
    assign o_free_count   = r_free_out;
    assign o_peak_used    = r_peak_out;

endmodule

@@ design/bitmap_slot_allocator.sv @@
// First-fit slot allocator over an occupancy bitmap, top level.
// Requests enter on s_axis: tuser carries the action, tdata the slot index.
// Results leave on m_axis: tuser carries the status, tdata the result fields.
// A write on the cfg port sets the number of managed slots (clamped to the
// capacity) and the free count to it, and clears the map and the peak count.
// Allocate scans the bitmap one 32-bit word per cycle through a priority
// encoder, from word 0 until a free slot is found or the last managed word
// is reached, then updates the map and registers the result. Release, query
// and the unused action skip the scan and go straight to the update. One
// request is in flight at a time; the next transfer is taken in the cycle
// after the update, while the result may still wait in the output register.
// When m_axis_tready is low the result holds; a finished request then waits
// in its update step until the output register is free.
// Reset (i_rst_n low, synchronous) sets 256 managed slots, an empty map and
// drops any pending result.
// Depends on bsa_pkg, bsa_ctrl and bsa_datapath.
module bitmap_slot_allocator import bsa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [SIZE_W-1:0]     i_cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] slot_index
    input  logic [ACT_W-1:0]      s_axis_tuser,   // [1:0] action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // granted_slot, slot_bit, free_count, peak_used
    output logic [STS_W-1:0]      m_axis_tuser    // [1:0] status
);

    t_dp_cmd             cmd;
    t_dp_sts             sts;
    logic [STS_W-1:0]    status;
    logic [SLOT_W-1:0]   granted_slot;
    logic                slot_bit;
    logic [SIZE_W-1:0]   free_count;
    logic [SIZE_W-1:0]   peak_used;

    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bsa_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_action       (s_axis_tuser),
        .i_slot_index   (s_axis_tdata[SLOT_W-1:0]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_status       (status),
        .o_granted_slot (granted_slot),
        .o_slot_bit     (slot_bit),
        .o_free_count   (free_count),
        .o_peak_used    (peak_used)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = OUT_DATA_W'({peak_used, free_count, slot_bit, granted_slot});

endmodule
